// ----- sv/slm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg: shared types and constants of the single-linkage merge block
// Transaction payloads, label table entry layout and controller states.
// ----------------------------------------------------------------------------
package slm_pkg;

	localparam int ID_W    = 10;
	localparam int DIST_W  = 32;
	localparam int COUNT_W = 11;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Operation codes of an input transaction.
	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_EDGE     = 1'b1;

	// Input transaction.
	typedef struct packed {
		logic              op;
		logic [ID_W-1:0]   cluster_a;
		logic [ID_W-1:0]   cluster_b;
		logic [DIST_W-1:0] edge_dist;
	} in_t;

	// Result transaction.
	typedef struct packed {
		logic [ID_W-1:0]   absorbed_cluster;
		logic [ID_W-1:0]   absorbing_cluster;
		logic [DIST_W-1:0] link_dist;
		logic              error;
	} out_t;

	// One label table entry: live flag and current label share a word.
	typedef struct packed {
		logic            live;
		logic [ID_W-1:0] label;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK_A,
		ST_LOOK_B,
		ST_SCAN
	} state_t;

endpackage

// ----- sv/slm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module slm_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/single_linkage_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_linkage_merge: single-linkage cluster merging over sorted edges
// Registers live cluster ids and merges clusters edge by edge, relabeling
// the label table with a read-modify-write sweep through one RAM.
// ----------------------------------------------------------------------------
//
// Channel   Ports                 Handshake
// input     start, busy, item     taken when start is high and busy is low
// result    done, result          valid for the one cycle that done is high
//
// A register transaction passes through ST_LOOK_A alone. An edge while one
// cluster or fewer is live is taken without raising busy. An edge that ends
// in an error or finds equal labels returns to idle from ST_LOOK_B; a merge
// runs the relabel sweep over the label RAM, one entry a cycle on its one read
// port. After reset a clearing pass over every entry holds busy high.
// DEPTH is the smaller of MAX_CLUSTERS and 1024. Results cannot be stalled.
// ----------------------------------------------------------------------------
module single_linkage_merge
	import slm_pkg::*;
#(
	parameter int MAX_CLUSTERS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	localparam int DEPTH = (MAX_CLUSTERS < (1 << ID_W)) ? MAX_CLUSTERS : (1 << ID_W);
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = AW + 1;

	state_t state_q, state_d;

	in_t               item_q;
	entry_t            entry_a_q;
	logic [ID_W-1:0]   from_q, to_q;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [AW-1:0]     clr_idx_q;
	logic [IW-1:0]     rd_idx_q;
	logic              valid_s1;
	logic [AW-1:0]     addr_s1;
	logic              done_q, done_d;
	out_t              result_q, result_d;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	entry_t            ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	logic a_in_range, b_in_range, a_ok, b_ok;
	logic accept;

	assign accept     = start && !busy;
	assign a_in_range = 32'(item_q.cluster_a) < MAX_CLUSTERS;
	assign b_in_range = 32'(item_q.cluster_b) < MAX_CLUSTERS;
	assign a_ok       = a_in_range && entry_a_q.live;
	assign b_ok       = b_in_range && ram_rdata.live;
	assign ram_rdata  = entry_t'(ram_rdata_raw);

	// Label table: live flag and label of every id.
	slm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_label_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	// Next state, RAM access and result.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		done_d    = 1'b0;
		result_d  = result_q;
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		ram_wdata = '0;
		ram_raddr = item.cluster_a[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_idx_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// An edge with one cluster or fewer live leaves no trace.
				if (accept && !(item.op == OP_EDGE && count_q <= COUNT_W'(1))) begin
					state_d = ST_LOOK_A;
				end
			end
			ST_LOOK_A: begin
				ram_raddr = item_q.cluster_b[AW-1:0];
				if (item_q.op == OP_REGISTER) begin
					if (a_in_range && !ram_rdata.live) begin
						ram_we          = 1'b1;
						ram_waddr       = item_q.cluster_a[AW-1:0];
						ram_wdata.live  = 1'b1;
						ram_wdata.label = item_q.cluster_a;
						if (count_q != COUNT_MAX) begin
							count_d = count_q + COUNT_W'(1);
						end
					end
					state_d = ST_IDLE;
				end else begin
					state_d = ST_LOOK_B;
				end
			end
			ST_LOOK_B: begin
				ram_raddr = '0;
				if (!(a_ok && b_ok)) begin
					done_d         = 1'b1;
					result_d       = '0;
					result_d.error = 1'b1;
					state_d        = ST_IDLE;
				end else if (entry_a_q.label == ram_rdata.label) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_raddr = rd_idx_q[AW-1:0];
				// Relabel an entry once its read data is back.
				if (valid_s1 && ram_rdata.live && ram_rdata.label == from_q) begin
					ram_we          = 1'b1;
					ram_waddr       = addr_s1;
					ram_wdata.live  = 1'b1;
					ram_wdata.label = to_q;
				end
				if (valid_s1 && rd_idx_q == IW'(DEPTH)) begin
					done_d                     = 1'b1;
					result_d.absorbed_cluster  = from_q;
					result_d.absorbing_cluster = to_q;
					result_d.link_dist         = item_q.edge_dist;
					result_d.error             = 1'b0;
					count_d                    = count_q - COUNT_W'(1);
					state_d                    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			count_q   <= '0;
			clr_idx_q <= '0;
			rd_idx_q  <= '0;
			valid_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			// Sweep read pointer and the stage that tracks returning data.
			if (state_q == ST_SCAN && rd_idx_q != IW'(DEPTH)) begin
				rd_idx_q <= rd_idx_q + IW'(1);
				valid_s1 <= 1'b1;
			end else if (state_q == ST_SCAN) begin
				valid_s1 <= 1'b0;
			end else begin
				rd_idx_q <= '0;
				valid_s1 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_LOOK_A) begin
			entry_a_q <= ram_rdata;
		end
		if (state_q == ST_LOOK_B) begin
			from_q <= entry_a_q.label;
			to_q   <= ram_rdata.label;
		end
		addr_s1  <= rd_idx_q[AW-1:0];
		result_q <= result_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- tb/sv/single_linkage_merge_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_linkage_merge_tb: self-checking bench for the single-linkage merger
// Drives register and edge transactions with random idle bursts and keeps its
// own copy of the label table and live count. It predicts every merge and
// error record and compares each strobed result against the oldest one.
// ----------------------------------------------------------------------------
module single_linkage_merge_tb;
	import slm_pkg::*;

	localparam int TABLE_SIZE   = 1024;
	localparam int RANDOM_ITEMS = 560;
	localparam int QUIET_TAIL   = 60;
	localparam int DRAIN_CYCLES = TABLE_SIZE + 16;
	localparam int STALL_LIMIT  = 8000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	logic done;
	out_t result;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct {
		in_t  stim;
		bit   typed;
		bit   has_res;
		out_t res;
	} row_t;

	row_t directed_rows[$];

	// Shadow copy of the block's state.
	bit               is_live [0:TABLE_SIZE-1];
	logic [ID_W-1:0]  label_of [0:TABLE_SIZE-1];
	logic [COUNT_W-1:0] live_total;
	logic [ID_W-1:0]  live_ids[$];

	out_t expected_merges[$];
	int   mismatch_count = 0;
	int   stall_cycles = 0;

	single_linkage_merge uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predicts the outcome of one accepted transaction and updates the shadow state.
	function automatic bit predict_merge(input in_t stim, output out_t res);
		logic [ID_W-1:0] from_lab;
		logic [ID_W-1:0] to_lab;
		res = '0;
		if (stim.op == OP_REGISTER) begin
			if (!is_live[stim.cluster_a]) begin
				is_live[stim.cluster_a] = 1'b1;
				label_of[stim.cluster_a] = stim.cluster_a;
				if (live_total != COUNT_MAX)
					live_total = live_total + 1'b1;
				live_ids.insert(live_ids.size(), stim.cluster_a);
			end
			return 1'b0;
		end
		// With one cluster or fewer live, edges are dropped before any lookup.
		if (live_total <= 1)
			return 1'b0;
		if (!is_live[stim.cluster_a] || !is_live[stim.cluster_b]) begin
			res.error = 1'b1;
			return 1'b1;
		end
		from_lab = label_of[stim.cluster_a];
		to_lab = label_of[stim.cluster_b];
		if (from_lab == to_lab)
			return 1'b0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (is_live[i] && label_of[i] == from_lab)
				label_of[i] = to_lab;
		end
		live_total = live_total - 1'b1;
		res.absorbed_cluster = from_lab;
		res.absorbing_cluster = to_lab;
		res.link_dist = stim.edge_dist;
		return 1'b1;
	endfunction

	function automatic in_t make_item(input logic op, input int a, input int b,
			input logic [DIST_W-1:0] d);
		in_t t;
		t.op = op;
		t.cluster_a = ID_W'(a);
		t.cluster_b = ID_W'(b);
		t.edge_dist = d;
		return t;
	endfunction

	task automatic add_row(input in_t stim, input bit typed, input bit has_res, input out_t res);
		row_t r;
		r.stim = stim;
		r.typed = typed;
		r.has_res = has_res;
		r.res = res;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	// Random transaction: mostly edges between live ids, some registers and noise.
	function automatic in_t random_item();
		int unsigned mode;
		int unsigned n;
		in_t t;
		mode = $urandom_range(0, 9);
		n = live_ids.size();
		t.edge_dist = $urandom;
		t.cluster_b = ID_W'($urandom_range(0, TABLE_SIZE - 1));
		t.cluster_a = ID_W'($urandom_range(0, TABLE_SIZE - 1));
		if (mode <= 2 || n < 2) begin
			t.op = OP_REGISTER;
		end else begin
			t.op = OP_EDGE;
			if (mode <= 8)
				t.cluster_b = live_ids[$urandom_range(0, n - 1)];
			if (mode <= 7)
				t.cluster_a = live_ids[$urandom_range(0, n - 1)];
		end
		return t;
	endfunction

	// Presents one transaction and holds it until the block takes it.
	task automatic issue(input row_t r);
		out_t pred;
		bit   has;
		item <= r.stim;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		has = predict_merge(r.stim, pred);
		if (r.typed) begin
			has = r.has_res;
			pred = r.res;
		end
		if (has)
			expected_merges.insert(expected_merges.size(), pred);
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 14)) @(posedge clk);
	endtask

	task automatic report_field(input string name, input logic [DIST_W-1:0] exp_v,
			input logic [DIST_W-1:0] act_v);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
	endtask

	// Result checker and stall watchdog.
	always @(posedge clk) begin
		out_t want;
		bit   bad;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (done) begin
				if (expected_merges.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time, result);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_merges[0];
					expected_merges.delete(0);
					bad = 1'b0;
					if (result.absorbed_cluster !== want.absorbed_cluster) begin
						report_field("absorbed_cluster", DIST_W'(want.absorbed_cluster),
							DIST_W'(result.absorbed_cluster));
						bad = 1'b1;
					end
					if (result.absorbing_cluster !== want.absorbing_cluster) begin
						report_field("absorbing_cluster", DIST_W'(want.absorbing_cluster),
							DIST_W'(result.absorbing_cluster));
						bad = 1'b1;
					end
					if (result.link_dist !== want.link_dist) begin
						report_field("link_dist", want.link_dist, result.link_dist);
						bad = 1'b1;
					end
					if (result.error !== want.error) begin
						report_field("error", DIST_W'(want.error), DIST_W'(result.error));
						bad = 1'b1;
					end
					if (bad)
						mismatch_count <= mismatch_count + 1;
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no transaction for %0d cycles", $time, stall_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		out_t err_res;
		out_t no_res;
		int   counted;
		row_t r;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		live_total = '0;
		no_res = '0;
		err_res = '0;
		err_res.error = 1'b1;

		// Directed table, built on an empty table after reset.
		add_row(make_item(OP_EDGE, 5, 6, 32'h1234_5678), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_REGISTER, 0, 1023, 32'hFFFF_FFFF), 1'b1, 1'b0, no_res);
		// A single live cluster hides the unregistered end.
		add_row(make_item(OP_EDGE, 0, 1, 32'h0000_0001), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_REGISTER, 1023, 0, 32'h0), 1'b1, 1'b0, no_res);
		// A repeated register leaves label and count alone.
		add_row(make_item(OP_REGISTER, 0, 0, 32'h0), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 0, 500, 32'h0000_8000), 1'b1, 1'b1, err_res);
		add_row(make_item(OP_EDGE, 500, 0, 32'hFFFF_FFFF), 1'b1, 1'b1, err_res);
		add_row(make_item(OP_EDGE, 0, 1023, 32'hFFFF_FFFF), 1'b1, 1'b1,
			out_t'{10'd0, 10'd1023, 32'hFFFF_FFFF, 1'b0});
		add_row(make_item(OP_EDGE, 1023, 0, 32'h0), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_REGISTER, 1, 0, 32'h0), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_REGISTER, 2, 0, 32'h0), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_REGISTER, 3, 1023, 32'h0), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 1, 2, 32'h0), 1'b1, 1'b1,
			out_t'{10'd1, 10'd2, 32'h0, 1'b0});
		// Equal labels give no record.
		add_row(make_item(OP_EDGE, 2, 2, 32'h0001_0000), 1'b1, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 3, 1, 32'h0001_0000), 1'b0, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 2, 0, 32'h0002_8000), 1'b0, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 1, 3, 32'h0003_0000), 1'b0, 1'b0, no_res);
		add_row(make_item(OP_REGISTER, 512, 511, 32'h0), 1'b0, 1'b0, no_res);
		add_row(make_item(OP_REGISTER, 511, 512, 32'h0), 1'b0, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 1023, 512, 32'h8000_0000), 1'b0, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 1023, 700, 32'h8000_0001), 1'b1, 1'b1, err_res);
		add_row(make_item(OP_EDGE, 511, 511, 32'hFFFF_FFFE), 1'b0, 1'b0, no_res);
		add_row(make_item(OP_EDGE, 3, 511, 32'hFFFF_FFFF), 1'b0, 1'b0, no_res);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (directed_rows[i]) begin
			if ($urandom_range(0, 3) == 0)
				idle_burst();
			issue(directed_rows[i]);
		end

		// Random part; the last stretch runs back to back.
		counted = 0;
		r.typed = 1'b0;
		r.has_res = 1'b0;
		r.res = '0;
		while (counted < RANDOM_ITEMS) begin
			if (counted < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
				idle_burst();
			r.stim = random_item();
			issue(r);
			counted++;
		end
		start <= 1'b0;

		// Drain outstanding results, then allow for one more relabel sweep.
		while (expected_merges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_merges.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
